>>> rtl/core/acestm_pkg.sv
`default_nettype none
package acestm_pkg;

  localparam int CHAN_W        = 24;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NCH           = 3;
  localparam int Q_W           = 16;
  localparam int DIV_STAGES    = Q_W / 2;
  // numerator and denominator stay below 2^57 for any fraction width 8..24
  localparam int DEN_W         = 2 * CHAN_W + 9;
  localparam int REM_W         = DEN_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DEN_W-1:0]  wide_t;
  typedef logic [Q_W-1:0]    quot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONEMAP_ENABLE = 1'b0,
    REG_PIXEL_ORDER    = 1'b1
  } cfg_reg_t;

  // pixel_order bit meanings
  localparam int ORDER_FOUR_BIT = 0;
  localparam int ORDER_BGR_BIT  = 1;

  localparam logic [CNT_W-1:0] COUNT_THREE = 3'd3;
  localparam logic [CNT_W-1:0] COUNT_FOUR  = 3'd4;
  localparam byte_t            BYTE_FULL   = 8'hFF;

  // floor(q * 255 / 2^16) for q below 1.0
  function automatic byte_t q_to_byte(input quot_t q);
    logic [Q_W+BYTE_W-1:0] p;
    p = {q, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, q};
    return p[Q_W+BYTE_W-1:Q_W];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/acestm_pix_if.sv
`default_nettype none
interface acestm_pix_in_if;
  import acestm_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t alpha_in;
  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface acestm_pix_out_if;
  import acestm_pkg::*;
  logic             valid;
  logic             ready;
  byte_t            byte_zero;
  byte_t            byte_one;
  byte_t            byte_two;
  byte_t            byte_three;
  logic [CNT_W-1:0] byte_count;
  modport source (output valid, output byte_zero, output byte_one, output byte_two,
                  output byte_three, output byte_count, input ready);
  modport sink (input valid, input byte_zero, input byte_one, input byte_two,
                input byte_three, input byte_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aces_tonemap_pixel_encoder_core.sv
// channel   dir  handshake        payload
// in_pix    in   valid/ready      red_in green_in blue_in alpha_in (Q8.16)
// out_pix   out  valid/ready      byte_zero..byte_three byte_count
// cfg       in   cfg_we           cfg_idx cfg_wdata
//
// one pixel per cycle when not stalled; stages: two for the squares and curve
// polynomials, one for the saturation compare, eight for the 16-bit quotient
// (two bits a stage), one for byte scaling and packing into the output register.
// synchronous active-low reset clears valid bits and loads register defaults.
// a stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module aces_tonemap_pixel_encoder_core #(
  parameter int FRAC_BITS = acestm_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  acestm_pix_in_if.sink                         in_pix,
  acestm_pix_out_if.source                      out_pix,
  input  wire                                   cfg_we,
  input  wire [acestm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [acestm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import acestm_pkg::*;

  localparam int LAT_INT = 2 + 1 + DIV_STAGES;

  logic             tm_en_r;
  logic [1:0]       order_r;
  logic             adv;
  logic             v_r [LAT_INT];
  byte_t            pl_r [LAT_INT][NCH+1];
  chan_t            x_in [NCH];
  wide_t            num [NCH];
  wide_t            den [NCH];
  quot_t            q [NCH];
  logic             sat [NCH];
  logic             out_valid_r;
  byte_t            b0_r, b1_r, b2_r, b3_r;
  logic [CNT_W-1:0] cnt_r;
  byte_t            ch_byte [NCH+1];
  byte_t            b0_nxt, b1_nxt, b2_nxt, b3_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  chan_t            raw [NCH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_en_r <= 1'b1;
      order_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_TONEMAP_ENABLE: tm_en_r <= cfg_wdata[0];
        REG_PIXEL_ORDER:    order_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign adv          = !out_valid_r || out_pix.ready;
  assign in_pix.ready = adv;

  assign x_in[0] = in_pix.red_in;
  assign x_in[1] = in_pix.green_in;
  assign x_in[2] = in_pix.blue_in;
  assign raw[0]  = in_pix.red_in;
  assign raw[1]  = in_pix.green_in;
  assign raw[2]  = in_pix.blue_in;
  assign raw[3]  = in_pix.alpha_in;

  acestm_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
    .clk (clk),
    .en  (adv),
    .x   (x_in),
    .num (num),
    .den (den)
  );

  acestm_div u_div (
    .clk (clk),
    .en  (adv),
    .num (num),
    .den (den),
    .q   (q),
    .sat (sat)
  );

  // pass-through bytes ride alongside the divider
  for (genvar c = 0; c <= NCH; c++) begin : g_plain
    logic [CHAN_W+BYTE_W-1:0] prod;
    byte_t                    pb;
    always_comb begin
      prod = (CHAN_W+BYTE_W)'(raw[c]) * (CHAN_W+BYTE_W)'(BYTE_FULL);
      // one extra bit so that 1.0 is representable at the widest fraction
      pb   = ((CHAN_W+1)'(raw[c]) >= ((CHAN_W+1)'(1) << FRAC_BITS)) ? BYTE_FULL
                                                    : BYTE_W'(prod >> FRAC_BITS);
    end
    always_ff @(posedge clk) begin
      if (adv) pl_r[0][c] <= pb;
    end
    for (genvar s = 1; s < LAT_INT; s++) begin : g_dly
      always_ff @(posedge clk) begin
        if (adv) pl_r[s][c] <= pl_r[s-1][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT_INT; s++) v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_pix.valid;
      for (int s = 1; s < LAT_INT; s++) v_r[s] <= v_r[s-1];
      out_valid_r <= v_r[LAT_INT-1];
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (tm_en_r) ch_byte[c] = sat[c] ? BYTE_FULL : q_to_byte(q[c]);
      else         ch_byte[c] = pl_r[LAT_INT-1][c];
    end
    ch_byte[NCH] = tm_en_r ? BYTE_FULL : pl_r[LAT_INT-1][NCH];
    b0_nxt  = order_r[ORDER_BGR_BIT] ? ch_byte[2] : ch_byte[0];
    b1_nxt  = ch_byte[1];
    b2_nxt  = order_r[ORDER_BGR_BIT] ? ch_byte[0] : ch_byte[2];
    b3_nxt  = order_r[ORDER_FOUR_BIT] ? ch_byte[NCH] : '0;
    cnt_nxt = order_r[ORDER_FOUR_BIT] ? COUNT_FOUR : COUNT_THREE;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r  <= b0_nxt;
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.byte_zero  = b0_r;
  assign out_pix.byte_one   = b1_r;
  assign out_pix.byte_two   = b2_r;
  assign out_pix.byte_three = b3_r;
  assign out_pix.byte_count = cnt_r;

endmodule
`default_nettype wire

>>> rtl/core/acestm_curve.sv
`default_nettype none
module acestm_curve #(
  parameter int FRAC_BITS = acestm_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                en,
  input  acestm_pkg::chan_t  x   [acestm_pkg::NCH],
  output acestm_pkg::wide_t  num [acestm_pkg::NCH],
  output acestm_pkg::wide_t  den [acestm_pkg::NCH]
);
  import acestm_pkg::*;

  localparam wide_t K_NUM_SQ = DEN_W'(251);
  localparam wide_t K_NUM_X  = DEN_W'(3);
  localparam wide_t K_DEN_SQ = DEN_W'(243);
  localparam wide_t K_DEN_X  = DEN_W'(59);
  localparam wide_t K_DEN_C  = DEN_W'(14) << (2 * FRAC_BITS);

  chan_t                x_r   [NCH];
  logic [2*CHAN_W-1:0]  sq_r  [NCH];
  wide_t                num_r [NCH];
  wide_t                den_r [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    wide_t sq_w, x_w, num_nxt, den_nxt;

    always_comb begin
      sq_w    = DEN_W'(sq_r[c]);
      x_w     = DEN_W'(x_r[c]);
      num_nxt = sq_w * K_NUM_SQ + ((x_w * K_NUM_X) << FRAC_BITS);
      den_nxt = sq_w * K_DEN_SQ + ((x_w * K_DEN_X) << FRAC_BITS) + K_DEN_C;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[c]   <= x[c];
        sq_r[c]  <= (2*CHAN_W)'(x[c]) * (2*CHAN_W)'(x[c]);
        num_r[c] <= num_nxt;
        den_r[c] <= den_nxt;
      end
    end

    assign num[c] = num_r[c];
    assign den[c] = den_r[c];
  end

endmodule
`default_nettype wire

>>> rtl/core/acestm_div.sv
`default_nettype none
module acestm_div (
  input  wire                clk,
  input  wire                en,
  input  acestm_pkg::wide_t  num [acestm_pkg::NCH],
  input  acestm_pkg::wide_t  den [acestm_pkg::NCH],
  output acestm_pkg::quot_t  q   [acestm_pkg::NCH],
  output logic               sat [acestm_pkg::NCH]
);
  import acestm_pkg::*;

  logic [REM_W-1:0] rem_r [DIV_STAGES+1][NCH];
  wide_t            den_r [DIV_STAGES+1][NCH];
  quot_t            q_r   [DIV_STAGES+1][NCH];
  logic             sat_r [DIV_STAGES+1][NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    // curve saturates at 1.0 when num >= den
    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[0][c] <= num[c] >= den[c];
        rem_r[0][c] <= (num[c] >= den[c]) ? '0 : REM_W'(num[c]);
        den_r[0][c] <= den[c];
        q_r[0][c]   <= '0;
      end
    end

    // restoring division, two quotient bits per stage
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_st
      logic [REM_W-1:0] d_w, r_a, r_b;
      logic             qa, qb;

      always_comb begin
        d_w = REM_W'(den_r[s-1][c]);
        r_a = rem_r[s-1][c] << 1;
        qa  = r_a >= d_w;
        if (qa) r_a = r_a - d_w;
        r_b = r_a << 1;
        qb  = r_b >= d_w;
        if (qb) r_b = r_b - d_w;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][c] <= r_b;
          den_r[s][c] <= den_r[s-1][c];
          q_r[s][c]   <= {q_r[s-1][c][Q_W-3:0], qa, qb};
          sat_r[s][c] <= sat_r[s-1][c];
        end
      end
    end

    assign q[c]   = q_r[DIV_STAGES][c];
    assign sat[c] = sat_r[DIV_STAGES][c];
  end

endmodule
`default_nettype wire

>>> bench/tb_aces_tonemap_pixel_encoder_core.sv
module tb_aces_tonemap_pixel_encoder_core;
  import acestm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_t            b0;
    byte_t            b1;
    byte_t            b2;
    byte_t            b3;
    logic [CNT_W-1:0] cnt;
  } pix_bytes_t;

  typedef struct {
    chan_t      r;
    chan_t      g;
    chan_t      b;
    chan_t      a;
    logic       chk;
    pix_bytes_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  acestm_pix_in_if  in_pix();
  acestm_pix_out_if out_pix();

  aces_tonemap_pixel_encoder_core u_top (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix.sink), .out_pix(out_pix.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  logic       tm_en;
  logic [1:0] order;
  pix_bytes_t pending_pix[$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  initial begin
    in_pix.valid = 1'b0;
    in_pix.red_in = '0;
    in_pix.green_in = '0;
    in_pix.blue_in = '0;
    in_pix.alpha_in = '0;
    out_pix.ready = 1'b0;
  end

  function automatic byte_t linear_byte(chan_t x);
    logic [63:0] p;
    if (x >= (24'd1 << 16)) return BYTE_FULL;
    p = 64'(x) * 255;
    return byte_t'(p >> 16);
  endfunction

  function automatic byte_t curve_byte(chan_t x);
    logic [63:0] xv, one, num, den, rem, q;
    xv = 64'(x);
    one = 64'd1 << 16;
    num = xv * (251 * xv + 3 * one);
    den = xv * (243 * xv + 59 * one) + 14 * one * one;
    if (num >= den) return BYTE_FULL;
    rem = num;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return byte_t'((q * 255) >> 16);
  endfunction

  function automatic pix_bytes_t encode_pixel(chan_t r, chan_t g, chan_t b, chan_t a);
    byte_t rb, gb, bb, ab;
    pix_bytes_t o;
    if (tm_en) begin
      rb = curve_byte(r);
      gb = curve_byte(g);
      bb = curve_byte(b);
      ab = BYTE_FULL;
    end else begin
      rb = linear_byte(r);
      gb = linear_byte(g);
      bb = linear_byte(b);
      ab = linear_byte(a);
    end
    o.b0 = order[ORDER_BGR_BIT] ? bb : rb;
    o.b1 = gb;
    o.b2 = order[ORDER_BGR_BIT] ? rb : bb;
    o.b3 = order[ORDER_FOUR_BIT] ? ab : 8'd0;
    o.cnt = order[ORDER_FOUR_BIT] ? COUNT_FOUR : COUNT_THREE;
    return o;
  endfunction

  // receiver: random stall and compare
  always @(posedge clk) begin
    pix_bytes_t e;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected output transaction");
        err_cnt++;
      end else begin
        e = pending_pix.pop_front();
        if (out_pix.byte_zero !== e.b0) begin
          $error("byte_zero exp %0d got %0d", e.b0, out_pix.byte_zero); err_cnt++;
        end
        if (out_pix.byte_one !== e.b1) begin
          $error("byte_one exp %0d got %0d", e.b1, out_pix.byte_one); err_cnt++;
        end
        if (out_pix.byte_two !== e.b2) begin
          $error("byte_two exp %0d got %0d", e.b2, out_pix.byte_two); err_cnt++;
        end
        if (out_pix.byte_three !== e.b3) begin
          $error("byte_three exp %0d got %0d", e.b3, out_pix.byte_three); err_cnt++;
        end
        if (out_pix.byte_count !== e.cnt) begin
          $error("byte_count exp %0d got %0d", e.cnt, out_pix.byte_count); err_cnt++;
        end
      end
    end
    out_pix.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TONEMAP_ENABLE) tm_en = val[0];
    else order = val;
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_pix.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // one pixel, with optional table value to cross-check the predictor
  task automatic send_pixel(chan_t r, chan_t g, chan_t b, chan_t a,
                            logic chk, pix_bytes_t tbl);
    pix_bytes_t e;
    e = encode_pixel(r, g, b, a);
    if (chk && e !== tbl) begin
      $error("table row exp %h got predictor %h", tbl, e);
      err_cnt++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.red_in <= r;
    in_pix.green_in <= g;
    in_pix.blue_in <= b;
    in_pix.alpha_in <= a;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    pending_pix.push_back(e);
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(3))
      0: return chan_t'($urandom);
      1: return chan_t'($urandom_range(24'h01FFFF));
      2: return chan_t'($urandom_range(24'h00FFFF));
      default: return chan_t'($urandom_range(24'h0FFFFF));
    endcase
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    pix_bytes_t z;
    z = '0;
    // all zeros, all ones, exact one, just below one, single set bits, mixed patterns
    dir_rows.push_back('{24'h0, 24'h0, 24'h0, 24'h0, 1'b0, z});
    dir_rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, z});
    dir_rows.push_back('{24'h010000, 24'h010000, 24'h010000, 24'h010000, 1'b0, z});
    dir_rows.push_back('{24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, z});
    dir_rows.push_back('{24'h000001, 24'h800000, 24'h008000, 24'h000100, 1'b0, z});
    dir_rows.push_back('{24'h555555, 24'hAAAAAA, 24'h00FFFF, 24'h010001, 1'b0, z});
    dir_rows.push_back('{24'h00F000, 24'h004000, 24'h000000, 24'hFFFFFF, 1'b0, z});
  end

  initial begin
    int n;
    tm_en = 1'b1;
    order = 2'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset defaults: tonemap on, RGB; zero and saturated pixels read off directly
    send_pixel(24'h0, 24'h0, 24'h0, 24'h0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, COUNT_THREE});
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 1'b1,
               '{8'd255, 8'd255, 8'd255, 8'd0, COUNT_THREE});
    drain_pipe();
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_TONEMAP_ENABLE, CFG_DATA_W'(m[2]));
      write_reg(REG_PIXEL_ORDER, m[1:0]);
      foreach (dir_rows[i])
        send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].a,
                   dir_rows[i].chk, dir_rows[i].exp);
      drain_pipe();
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 19 : 0;
      n = 0;
      while (n < 115) begin
        if (n % 45 == 0) begin
          drain_pipe();
          write_reg(REG_TONEMAP_ENABLE, CFG_DATA_W'($urandom_range(1)));
          write_reg(REG_PIXEL_ORDER, CFG_DATA_W'($urandom_range(3)));
        end
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
        n++;
      end
    end
    drain_pipe();
    if (err_cnt == 0) begin
      $display("tb_aces_tonemap_pixel_encoder_core: clean");
    end else begin
      $display("tb_aces_tonemap_pixel_encoder_core: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_aces_tonemap_pixel_encoder_core: errors");
    $finish;
  end
endmodule
